@@ rtl/rrtu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rrtu_pkg;

   localparam int FIELD_MAX_DEFAULT = 100;
   localparam int WORD_QUEUE_DEPTH  = 2;
   localparam int RESULT_FIFO_DEPTH = 4;

   localparam logic [5:0] END_DIGIT  = 6'd39;
   localparam logic [9:0] OFFSET_MAX = 10'd1023;

   localparam logic [1:0] FIELD_BOARD = 2'd0;
   localparam logic [1:0] FIELD_SYSOP = 2'd1;
   localparam logic [1:0] FIELD_MISC  = 2'd2;
   localparam logic [1:0] FIELD_NONE  = 2'd3;

   // reciprocal of 5 for values below 2^15
   localparam logic [15:0] RECIP_FIVE = 16'd52429;
   localparam int          RECIP_SHIFT = 18;

   typedef struct packed {
      logic [5:0] digit0;
      logic [5:0] digit1;
      logic [5:0] digit2;
      logic       first_word;
      logic       last_word;
      logic [7:0] board_length;
      logic [7:0] sysop_length;
      logic [7:0] misc_length;
   } word_item_type;

   typedef struct packed {
      logic [7:0] character;
      logic [1:0] field_id;
      logic [6:0] position;
      logic       last;
   } result_type;

   function automatic logic [7:0] alpha_lookup(input logic [5:0] digit);
      logic [7:0] c;
      unique case (digit)
         6'd0:  c = " ";
         6'd1:  c = "E";
         6'd2:  c = "A";
         6'd3:  c = "N";
         6'd4:  c = "R";
         6'd5:  c = "O";
         6'd6:  c = "S";
         6'd7:  c = "T";
         6'd8:  c = "I";
         6'd9:  c = "L";
         6'd10: c = "C";
         6'd11: c = "H";
         6'd12: c = "B";
         6'd13: c = "D";
         6'd14: c = "M";
         6'd15: c = "U";
         6'd16: c = "G";
         6'd17: c = "P";
         6'd18: c = "K";
         6'd19: c = "Y";
         6'd20: c = "W";
         6'd21: c = "F";
         6'd22: c = "V";
         6'd23: c = "J";
         6'd24: c = "X";
         6'd25: c = "Z";
         6'd26: c = "Q";
         6'd27: c = "-";
         6'd28: c = "'";
         6'd29: c = "0";
         6'd30: c = "1";
         6'd31: c = "2";
         6'd32: c = "3";
         6'd33: c = "4";
         6'd34: c = "5";
         6'd35: c = "6";
         6'd36: c = "7";
         6'd37: c = "8";
         6'd38: c = "9";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= "A") && (c <= "Z");
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= "a") && (c <= "z");
   endfunction

endpackage
`default_nettype wire

@@ rtl/radix40_record_text_unpacker.sv @@
// channel   | handshake              | payload
// ----------+------------------------+--------------------------------------------------
// request   | req_push / req_full    | packed_word, first_word, last_word, three lengths
// result    | rsp_pop / rsp_empty    | character, field_id, position, last
//
// each request gives up to three results, one digit handled per cycle in the back end
// while the result fifo has room; a result is held back until it is known whether it
// closes its word, and so whether its last flag is set
// reset is synchronous; lengths, offset and case state clear, no clearing pass
// the back end stalls only when the four-entry result fifo is full
`timescale 1ns / 1ps
`default_nettype none
module radix40_record_text_unpacker #(
   parameter int FIELD_MAX = rrtu_pkg::FIELD_MAX_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [15:0] req_packed_word,
   input  wire logic        req_first_word,
   input  wire logic        req_last_word,
   input  wire logic [7:0]  req_board_length,
   input  wire logic [7:0]  req_sysop_length,
   input  wire logic [7:0]  req_misc_length,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_character,
   output logic [1:0]       rsp_field_id,
   output logic [6:0]       rsp_position,
   output logic             rsp_last
);
   import rrtu_pkg::*;

   localparam int WORD_W = $bits(word_item_type);
   localparam int RES_W  = $bits(result_type);

   word_item_type   front_data, queue_data;
   logic [WORD_W-1:0] queue_vec;
   logic            front_push, queue_full, queue_empty, queue_pop;
   result_type      back_data, rsp_data;
   logic [RES_W-1:0] rsp_vec;
   logic            back_push, res_full;

   rrtu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_packed_word  (req_packed_word),
      .req_first_word   (req_first_word),
      .req_last_word    (req_last_word),
      .req_board_length (req_board_length),
      .req_sysop_length (req_sysop_length),
      .req_misc_length  (req_misc_length),
      .q_push           (front_push),
      .q_data           (front_data),
      .q_full           (queue_full)
   );

   rrtu_fifo #(
      .WIDTH (WORD_W),
      .DEPTH (WORD_QUEUE_DEPTH)
   ) u_word_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_vec),
      .empty     (queue_empty)
   );

   assign queue_data = queue_vec;

   rrtu_back #(
      .FIELD_MAX (FIELD_MAX)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (queue_empty),
      .q_data   (queue_data),
      .q_pop    (queue_pop),
      .out_push (back_push),
      .out_data (back_data),
      .out_full (res_full)
   );

   rrtu_fifo #(
      .WIDTH (RES_W),
      .DEPTH (RESULT_FIFO_DEPTH)
   ) u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_vec),
      .empty     (rsp_empty)
   );

   assign rsp_data      = rsp_vec;
   assign rsp_character = rsp_data.character;
   assign rsp_field_id  = rsp_data.field_id;
   assign rsp_position  = rsp_data.position;
   assign rsp_last      = rsp_data.last;

endmodule
`default_nettype wire

@@ rtl/rrtu_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rrtu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [IW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/rrtu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rrtu_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [15:0]            req_packed_word,
   input  wire logic                   req_first_word,
   input  wire logic                   req_last_word,
   input  wire logic [7:0]             req_board_length,
   input  wire logic [7:0]             req_sysop_length,
   input  wire logic [7:0]             req_misc_length,
   output logic                        q_push,
   output rrtu_pkg::word_item_type     q_data,
   input  wire logic                   q_full
);
   import rrtu_pkg::*;

   logic        a_valid_ff, a_valid_in;
   logic        b_valid_ff, b_valid_in;
   logic [15:0] a_word_ff;
   logic        a_first_ff, a_last_ff;
   logic [7:0]  a_blen_ff, a_slen_ff, a_mlen_ff;
   logic [10:0] b_quot_ff;
   logic [5:0]  b_digit2_ff;
   logic        b_first_ff, b_last_ff;
   logic [7:0]  b_blen_ff, b_slen_ff, b_mlen_ff;

   logic        accept, a_move, b_move, b_free;
   logic [28:0] prod_a;
   logic [10:0] quot_a;
   logic [15:0] quot_a_x40;
   logic [23:0] prod_b;
   logic [5:0]  quot_b;
   logic [10:0] quot_b_x40;
   logic [10:0] rem_b;
   logic [5:0]  top_digit;

   assign b_move   = b_valid_ff && !q_full;
   assign b_free   = !b_valid_ff || !q_full;
   assign a_move   = a_valid_ff && b_free;
   assign req_full = a_valid_ff && !b_free;
   assign accept   = req_push && !req_full;
   assign q_push   = b_move;

   // word / 40 as (word / 8) / 5
   always_comb begin
      prod_a     = 29'(a_word_ff[15:3]) * 29'(RECIP_FIVE);
      quot_a     = 11'(prod_a >> RECIP_SHIFT);
      quot_a_x40 = (16'(quot_a) << 5) + (16'(quot_a) << 3);
   end

   always_comb begin
      prod_b     = 24'(b_quot_ff[10:3]) * 24'(RECIP_FIVE);
      quot_b     = 6'(prod_b >> RECIP_SHIFT);
      quot_b_x40 = (11'(quot_b) << 5) + (11'(quot_b) << 3);
      rem_b      = b_quot_ff - quot_b_x40;
      top_digit  = (quot_b >= 6'd40) ? quot_b - 6'd40 : quot_b;
   end

   always_comb begin
      q_data.digit0       = top_digit;
      q_data.digit1       = rem_b[5:0];
      q_data.digit2       = b_digit2_ff;
      q_data.first_word   = b_first_ff;
      q_data.last_word    = b_last_ff;
      q_data.board_length = b_blen_ff;
      q_data.sysop_length = b_slen_ff;
      q_data.misc_length  = b_mlen_ff;
   end

   assign a_valid_in = accept || (a_valid_ff && !a_move);
   assign b_valid_in = a_move || (b_valid_ff && !b_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_word_ff  <= req_packed_word;
         a_first_ff <= req_first_word;
         a_last_ff  <= req_last_word;
         a_blen_ff  <= req_board_length;
         a_slen_ff  <= req_sysop_length;
         a_mlen_ff  <= req_misc_length;
      end
      if (a_move) begin
         b_quot_ff   <= quot_a;
         b_digit2_ff <= 6'(a_word_ff - quot_a_x40);
         b_first_ff  <= a_first_ff;
         b_last_ff   <= a_last_ff;
         b_blen_ff   <= a_blen_ff;
         b_slen_ff   <= a_slen_ff;
         b_mlen_ff   <= a_mlen_ff;
      end
   end

endmodule
`default_nettype wire

@@ rtl/rrtu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rrtu_back #(
   parameter int FIELD_MAX = rrtu_pkg::FIELD_MAX_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_empty,
   input  wire rrtu_pkg::word_item_type q_data,
   output logic                        q_pop,
   output logic                        out_push,
   output rrtu_pkg::result_type        out_data,
   input  wire logic                   out_full
);
   import rrtu_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [9:0] offset_ff, offset_in;
   logic       capital_ff, capital_in;
   logic       ended_ff, ended_in;
   logic [7:0] blen_ff, slen_ff, mlen_ff;
   result_type held_ff, held_in;
   logic       held_valid_ff, held_valid_in;
   logic       held_final_ff, held_final_in;

   logic       go, busy, start, end_word;
   logic [5:0] digit;
   logic [7:0] blen, slen, mlen;
   logic [9:0] off;
   logic [8:0] sum_bs;
   logic [9:0] sum_all;
   logic [1:0] fid;
   logic [9:0] pos;
   logic       cap, ended, emit;
   logic [7:0] raw_char, new_char;
   result_type new_res;

   assign go       = !out_full;
   assign busy     = !q_empty;
   assign start    = busy && (phase_ff == 2'd0) && q_data.first_word;
   assign end_word = busy && (phase_ff == 2'd2);
   assign q_pop    = go && end_word;

   always_comb begin
      unique case (phase_ff)
         2'd0:    digit = q_data.digit0;
         2'd1:    digit = q_data.digit1;
         2'd2:    digit = q_data.digit2;
         default: digit = q_data.digit0;
      endcase
   end

   always_comb begin
      blen  = start ? q_data.board_length : blen_ff;
      slen  = start ? q_data.sysop_length : slen_ff;
      mlen  = start ? q_data.misc_length  : mlen_ff;
      off   = start ? '0   : offset_ff;
      cap   = start ? 1'b1 : capital_ff;
      ended = start ? 1'b0 : ended_ff;

      sum_bs  = 9'(blen) + 9'(slen);
      sum_all = 10'(sum_bs) + 10'(mlen);

      if (off < 10'(blen)) begin
         fid = FIELD_BOARD;
         pos = off;
      end else if (off < 10'(sum_bs)) begin
         fid = FIELD_SYSOP;
         pos = off - 10'(blen);
      end else if (off < sum_all) begin
         fid = FIELD_MISC;
         pos = off - 10'(sum_bs);
      end else begin
         fid = FIELD_NONE;
         pos = '0;
      end

      emit     = 1'b0;
      raw_char = alpha_lookup(digit);
      new_char = raw_char;
      if (fid != FIELD_NONE) begin
         if (pos == '0) begin
            cap   = 1'b1;
            ended = 1'b0;
         end
         if ((pos < 10'(FIELD_MAX)) && !ended) begin
            if (digit >= END_DIGIT) begin
               ended = 1'b1;
            end else begin
               if (cap && is_lower(raw_char)) begin
                  new_char = raw_char - 8'd32;
               end else if (!cap && is_upper(raw_char)) begin
                  new_char = raw_char + 8'd32;
               end
               cap  = !(is_upper(new_char) || is_lower(new_char));
               emit = 1'b1;
            end
         end
      end

      new_res.character = new_char;
      new_res.field_id  = fid;
      new_res.position  = pos[6:0];
      new_res.last      = 1'b0;
   end

   // one result is held back until it is known whether it closes its word
   always_comb begin
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      held_final_in = held_final_ff;
      out_push      = 1'b0;
      out_data      = held_ff;
      out_data.last = held_final_ff;
      if (go) begin
         if (held_valid_ff && held_final_ff) begin
            out_push      = 1'b1;
            held_in       = new_res;
            held_valid_in = busy && emit;
            held_final_in = busy && emit && end_word;
         end else if (busy && emit) begin
            out_push      = held_valid_ff;
            held_in       = new_res;
            held_valid_in = 1'b1;
            held_final_in = end_word;
         end else if (end_word && held_valid_ff) begin
            held_final_in = 1'b1;
         end
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      offset_in  = offset_ff;
      capital_in = capital_ff;
      ended_in   = ended_ff;
      if (go && busy) begin
         phase_in   = end_word ? 2'd0 : phase_ff + 2'd1;
         capital_in = cap;
         ended_in   = ended;
         offset_in  = (off < OFFSET_MAX) ? off + 10'd1 : off;
         if (end_word && q_data.last_word) begin
            offset_in = OFFSET_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 2'd0;
         offset_ff     <= '0;
         capital_ff    <= 1'b1;
         ended_ff      <= 1'b0;
         blen_ff       <= '0;
         slen_ff       <= '0;
         mlen_ff       <= '0;
         held_valid_ff <= 1'b0;
         held_final_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         capital_ff    <= capital_in;
         ended_ff      <= ended_in;
         held_valid_ff <= held_valid_in;
         held_final_ff <= held_final_in;
         if (go && start) begin
            blen_ff <= q_data.board_length;
            slen_ff <= q_data.sysop_length;
            mlen_ff <= q_data.misc_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

`ifndef ASSERT_OFF
   a_final_needs_valid: assert property (@(posedge clock) disable iff (reset)
      held_final_ff |-> held_valid_ff)
      else $error("held result marked final but not valid");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("digit phase out of range");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into full fifo");

   a_last_word_parks_offset: assert property (@(posedge clock) disable iff (reset)
      (go && end_word && q_data.last_word) |=> (offset_ff == OFFSET_MAX))
      else $error("offset not parked after last word");
`endif

endmodule
`default_nettype wire

@@ tb/sv/radix40_record_text_unpacker_tb.sv @@
`timescale 1ns / 1ps
module radix40_record_text_unpacker_tb;
   import rrtu_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int TAIL_CYCLES = 20;
   localparam int PHASE_ITEMS = 40;

   class text_scoreboard;
      result_type expected_chars[$];
      int errors;
      logic [9:0] char_offset;
      bit capital_next;
      bit field_ended;
      int lengths[3];
      string alphabet;

      function new();
         errors = 0;
         char_offset = '0;
         capital_next = 1'b1;
         field_ended = 1'b0;
         lengths = '{0, 0, 0};
         alphabet = " EANROSTILCHBDMUGPKYWFVJXZQ-'0123456789";
      endfunction

      function void note_request(input logic [15:0] word, input logic first,
                                 input logic last, input logic [7:0] b, s, m);
         int w;
         int off;
         int pos;
         int n;
         int digits[3];
         logic [1:0] fid;
         logic [7:0] c;
         result_type produced[3];
         if (first) begin
            lengths = '{int'(b), int'(s), int'(m)};
            char_offset = '0;
            capital_next = 1'b1;
            field_ended = 1'b0;
         end
         w = int'(word);
         digits[2] = w % 40;
         w = w / 40;
         digits[1] = w % 40;
         w = w / 40;
         digits[0] = w % 40;
         n = 0;
         for (int k = 0; k < 3; k++) begin
            off = int'(char_offset);
            pos = 0;
            if (off < lengths[0]) begin
               fid = FIELD_BOARD;
               pos = off;
            end else if (off < lengths[0] + lengths[1]) begin
               fid = FIELD_SYSOP;
               pos = off - lengths[0];
            end else if (off < lengths[0] + lengths[1] + lengths[2]) begin
               fid = FIELD_MISC;
               pos = off - lengths[0] - lengths[1];
            end else begin
               fid = FIELD_NONE;
            end
            if (fid != FIELD_NONE) begin
               if (pos == 0) begin
                  capital_next = 1'b1;
                  field_ended = 1'b0;
               end
               if (pos < FIELD_MAX_DEFAULT && !field_ended) begin
                  if (digits[k] == int'(END_DIGIT)) begin
                     field_ended = 1'b1;
                  end else begin
                     c = alphabet[digits[k]];
                     if (!capital_next && c >= "A" && c <= "Z") c = c + 8'd32;
                     capital_next = !((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"));
                     produced[n] = '{c, fid, 7'(pos), 1'b0};
                     n++;
                  end
               end
            end
            if (char_offset != OFFSET_MAX) char_offset = char_offset + 10'd1;
         end
         if (n > 0) produced[n - 1].last = 1'b1;
         for (int k = 0; k < n; k++) expected_chars.push_back(produced[k]);
         if (last) char_offset = OFFSET_MAX;
      endfunction

      function void check_result(input result_type got);
         result_type want;
         if (expected_chars.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected character %h field %0d pos %0d last %b",
                        got.character, got.field_id, got.position, got.last);
         end else begin
            want = expected_chars.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected char %h field %0d pos %0d last %b,",
                           want.character, want.field_id, want.position, want.last,
                           " got char %h field %0d pos %0d last %b",
                           got.character, got.field_id, got.position, got.last);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [15:0] req_packed_word = '0;
   logic        req_first_word = 1'b0;
   logic        req_last_word = 1'b0;
   logic [7:0]  req_board_length = '0;
   logic [7:0]  req_sysop_length = '0;
   logic [7:0]  req_misc_length = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_character;
   logic [1:0]  rsp_field_id;
   logic [6:0]  rsp_position;
   logic        rsp_last;

   text_scoreboard board;
   int idle_pct = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int quiet_cycles = 0;

   radix40_record_text_unpacker u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_packed_word(req_packed_word),
      .req_first_word(req_first_word),
      .req_last_word(req_last_word),
      .req_board_length(req_board_length),
      .req_sysop_length(req_sysop_length),
      .req_misc_length(req_misc_length),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_character(rsp_character),
      .rsp_field_id(rsp_field_id),
      .rsp_position(rsp_position),
      .rsp_last(rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            board.check_result(result_type'{rsp_character, rsp_field_id, rsp_position,
                                            rsp_last});
         rsp_pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic int pick_digit();
      if ($urandom_range(99) < 8) return int'(END_DIGIT);
      return $urandom_range(38);
   endfunction

   function automatic logic [15:0] pick_word();
      int sel;
      sel = $urandom_range(99);
      if (sel < 15) return 16'($urandom_range(65535));
      if (sel < 20) return 16'(64000 + $urandom_range(1535));
      return 16'(pick_digit() * 1600 + pick_digit() * 40 + pick_digit());
   endfunction

   function automatic logic [7:0] pick_length();
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) return 8'd0;
      if (sel < 20) return 8'd255;
      if (sel < 40) return 8'($urandom_range(254, 100));
      return 8'($urandom_range(20, 1));
   endfunction

   task automatic send_request(input logic [15:0] word, input logic first, input logic last,
                               input logic [7:0] b, input logic [7:0] s, input logic [7:0] m);
      while ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_packed_word <= word;
      req_first_word <= first;
      req_last_word <= last;
      req_board_length <= b;
      req_sysop_length <= s;
      req_misc_length <= m;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(word, first, last, b, s, m);
      sent_count++;
   endtask

   task automatic send_record(input int words, input logic [7:0] b, input logic [7:0] s,
                              input logic [7:0] m, input bit closed, input int noise);
      for (int k = 0; k < words; k++) begin
         if (k == 0)
            send_request(pick_word(), 1'b1, closed && words == 1, b, s, m);
         else
            send_request(pick_word(), 1'b0, closed && k == words - 1,
                         pick_length(), pick_length(), pick_length());
      end
      for (int k = 0; k < noise; k++)
         send_request(pick_word(), 1'b0, 1'($urandom_range(1)),
                      pick_length(), pick_length(), pick_length());
   endtask

   task automatic random_records(input int target);
      int goal;
      int sel;
      int words;
      goal = sent_count + target;
      while (sent_count < goal) begin
         sel = $urandom_range(99);
         if (sel < 70) words = $urandom_range(10, 1);
         else if (sel < 90) words = $urandom_range(30, 11);
         else words = $urandom_range(45, 35);
         sel = $urandom_range(99);
         if (sel < 85)
            send_record(words, pick_length(), pick_length(), pick_length(), 1'b1, 0);
         else if (sel < 95)
            send_record(words, pick_length(), pick_length(), pick_length(), 1'b0, 0);
         else
            send_record(words, pick_length(), pick_length(), pick_length(), 1'b1,
                        $urandom_range(3, 1));
      end
   endtask

   initial begin
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // nothing latched yet, so all dropped
      send_request(16'd12345, 1'b0, 1'b0, 8'd7, 8'd7, 8'd7);
      // short fields, all-zero word, all-ones word, top digit wrap, end digits
      send_request(16'd0, 1'b1, 1'b0, 8'd3, 8'd4, 8'd2);
      send_request(16'd65535, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0);
      send_request(16'd64000, 1'b0, 1'b0, 8'd255, 8'd255, 8'd255);
      send_request(16'd62400, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0);
      send_request(16'd1599, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0);
      send_request(16'd1683, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
      // words after the last one are dropped
      send_request(16'd20000, 1'b0, 1'b0, 8'd9, 8'd9, 8'd9);
      send_request(16'd30000, 1'b0, 1'b1, 8'd9, 8'd9, 8'd9);
      // empty fields
      send_request(16'd1683, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0);
      // widest fields with mixed letters, punctuation and end digits
      send_request(16'd8160, 1'b1, 1'b0, 8'd255, 8'd255, 8'd255);
      send_request(16'd62439, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0);
      send_request(16'(27 * 1600 + 1 * 40 + 28), 1'b0, 1'b0, 8'd0, 8'd0, 8'd0);
      send_request(16'(38 * 1600 + 13 * 40 + 25), 1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
      // one character per field, each a field start
      send_request(16'(2 * 1600 + 3 * 40 + 4), 1'b1, 1'b1, 8'd1, 8'd1, 8'd1);

      // long record past the position cut and on into the sysop field
      send_record(100, 8'd255, 8'd255, 8'd255, 1'b1, 0);
      send_record(4, 8'd2, 8'd3, 8'd4, 1'b1, 0);

      idle_pct = 0;
      stall_pct = 0;
      random_records(PHASE_ITEMS);
      idle_pct = 58;
      stall_pct = 0;
      random_records(PHASE_ITEMS);
      idle_pct = 0;
      stall_pct = 58;
      random_records(PHASE_ITEMS);
      idle_pct = 8;
      stall_pct = 8;
      random_records(PHASE_ITEMS);
      req_push <= 1'b0;

      while (board.expected_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/rrtu_pkg.sv
rtl/rrtu_fifo.sv
rtl/rrtu_front.sv
rtl/rrtu_back.sv
rtl/radix40_record_text_unpacker.sv
tb/sv/radix40_record_text_unpacker_tb.sv
